@@ rtl/core/lfu_pkg.sv @@
// Shared types and constants for the LFU replacement policy core.
package lfu_pkg;

    // Width of the key field on the ports.
    localparam int KEY_W = 32;

    typedef enum logic [1:0] {
        FUNC_PUT    = 2'd0,
        FUNC_GET    = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_EVICT  = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_HIT     = 3'd0,
        ST_ABSENT  = 3'd1,
        ST_INSERT  = 3'd2,
        ST_FULL    = 3'd3,
        ST_EVICTED = 3'd4,
        ST_EMPTY   = 3'd5
    } t_status;

    typedef struct packed {
        t_func              func;
        logic [KEY_W-1:0]   key;
    } t_in_word;

    typedef struct packed {
        t_status            status;
        logic [KEY_W-1:0]   out_key;
    } t_out_word;

endpackage

@@ rtl/core/lfu_replacement_policy_core.sv @@
// LFU replacement policy core with least-recently-used tie-break.
//
//  Channel   Direction  Handshake            Word
//  request   in         i_valid / o_stall    i_word (func, key)
//  result    out        o_valid / i_stall    o_word (status, out_key)
//
// Every request word produces exactly one result word. A word is captured in
// an input register, the lookup, update and victim search happen in one pass
// of logic, and the result lands in an output register. The table takes one
// word per cycle unless o_stall is high; a result is valid once its request
// leaves the input register. Reset (synchronous, active low) empties the
// table by clearing the entry valid bits only. While the result register is
// held by i_stall, the word in the input register waits and o_stall rises.
module lfu_replacement_policy_core
    import lfu_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int KEY_BITS   = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_word  i_word,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_word
);

    // Stored key width: keys are masked to KEY_BITS and never exceed the port width.
    localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    // Rank and slot index width.
    localparam int RW = $clog2(CAPACITY);
    // Leaf count of the victim search tree, padded to a power of two.
    localparam int NP = 1 << RW;
    localparam int MW = COUNT_BITS + RW;

    // Input stage.
    logic     r_in_vld;
    t_in_word r_in_word;

    // Output stage.
    logic      r_out_vld;
    t_out_word r_out_word;
    t_out_word n_out_word;

    // Table state. Only the valid bits are reset.
    logic [CAPACITY-1:0]   r_valid;
    logic [KW-1:0]         r_key   [CAPACITY];
    logic [COUNT_BITS-1:0] r_count [CAPACITY];
    logic [RW-1:0]         r_rank  [CAPACITY];

    logic [CAPACITY-1:0]   n_valid;
    logic [COUNT_BITS-1:0] n_count [CAPACITY];
    logic [RW-1:0]         n_rank  [CAPACITY];
    logic                  n_write_key;

    logic w_adv;

    // The input word moves on when the output register is free or is being taken.
    assign w_adv   = r_in_vld && (!r_out_vld || !i_stall);
    assign o_stall = r_in_vld && !w_adv;
    assign o_valid = r_out_vld;
    assign o_word  = r_out_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_stall) begin
            r_in_vld <= i_valid;
        end
        if (!o_stall && i_valid) begin
            r_in_word <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
        if (w_adv) begin
            r_out_word <= n_out_word;
        end
    end

    // Lookup: key match, lowest free slot and victim search.
    logic [KW-1:0]       w_key;
    logic [CAPACITY-1:0] w_match;
    logic                w_hit;
    logic [RW-1:0]       w_hit_rank;
    logic                w_full;
    logic [RW-1:0]       w_free_idx;

    logic          tr_v [2*NP];
    logic [MW-1:0] tr_m [2*NP];
    logic [RW-1:0] tr_i [2*NP];

    logic [CAPACITY-1:0] w_vic_oh;
    logic [RW-1:0]       w_vic_rank;
    logic [KW-1:0]       w_vic_key;

    assign w_key = r_in_word.key[KW-1:0];

    always_comb begin
        w_hit_rank = '0;
        w_free_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_match[i] = r_valid[i] && (r_key[i] == w_key);
            if (w_match[i]) begin
                w_hit_rank = w_hit_rank | r_rank[i];
            end
        end
        // Lowest-numbered free slot wins.
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free_idx = RW'(i);
            end
        end
        w_hit  = |w_match;
        w_full = &r_valid;
    end

    // Victim search: the smallest {count, inverted rank} among valid entries,
    // so equal counts fall to the oldest entry. Ranks of valid entries are
    // distinct, so no two candidates ever compare equal.
    always_comb begin
        for (int n = 0; n < 2 * NP; n++) begin
            tr_v[n] = 1'b0;
            tr_m[n] = '0;
            tr_i[n] = '0;
        end
        for (int i = 0; i < NP; i++) begin
            tr_i[NP + i] = RW'(i);
            if (i < CAPACITY) begin
                tr_v[NP + i] = r_valid[i];
                tr_m[NP + i] = {r_count[i], ~r_rank[i]};
            end
        end
        for (int n = NP - 1; n >= 1; n--) begin
            if (!tr_v[2*n] || (tr_v[2*n+1] && (tr_m[2*n+1] < tr_m[2*n]))) begin
                tr_v[n] = tr_v[2*n+1];
                tr_m[n] = tr_m[2*n+1];
                tr_i[n] = tr_i[2*n+1];
            end else begin
                tr_v[n] = tr_v[2*n];
                tr_m[n] = tr_m[2*n];
                tr_i[n] = tr_i[2*n];
            end
        end
    end

    always_comb begin
        w_vic_rank = '0;
        w_vic_key  = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_vic_oh[i] = tr_v[1] && (tr_i[1] == RW'(i));
            if (w_vic_oh[i]) begin
                w_vic_rank = w_vic_rank | r_rank[i];
                w_vic_key  = w_vic_key | r_key[i];
            end
        end
    end

    // Operation decode into one of three table actions on a selected slot set.
    logic                do_touch;
    logic                do_insert;
    logic                do_drop;
    logic [CAPACITY-1:0] w_sel;
    logic [RW-1:0]       w_sel_rank;

    always_comb begin
        do_touch   = 1'b0;
        do_insert  = 1'b0;
        do_drop    = 1'b0;
        w_sel      = w_match;
        w_sel_rank = w_hit_rank;
        n_out_word = '{status: ST_HIT, out_key: '0};
        case (r_in_word.func)
            FUNC_PUT, FUNC_GET: begin
                if (w_hit) begin
                    do_touch = 1'b1;
                end else if (r_in_word.func == FUNC_GET) begin
                    n_out_word.status = ST_ABSENT;
                end else if (w_full) begin
                    n_out_word.status = ST_FULL;
                end else begin
                    do_insert         = 1'b1;
                    n_out_word.status = ST_INSERT;
                end
            end
            FUNC_REMOVE: begin
                if (w_hit) begin
                    do_drop = 1'b1;
                end else begin
                    n_out_word.status = ST_ABSENT;
                end
            end
            FUNC_EVICT: begin
                if (tr_v[1]) begin
                    do_drop            = 1'b1;
                    w_sel              = w_vic_oh;
                    w_sel_rank         = w_vic_rank;
                    n_out_word.status  = ST_EVICTED;
                    n_out_word.out_key = KEY_W'(w_vic_key);
                end else begin
                    n_out_word.status = ST_EMPTY;
                end
            end
            default: begin
                n_out_word.status = ST_ABSENT;
            end
        endcase
    end

    // Per-entry next state. Touch promotes the selected entry to rank zero and
    // ages the newer ones; insert ages every valid entry; drop closes the rank gap.
    always_comb begin
        n_write_key = do_insert;
        for (int i = 0; i < CAPACITY; i++) begin
            n_valid[i] = r_valid[i];
            n_count[i] = r_count[i];
            n_rank[i]  = r_rank[i];
            if (do_touch) begin
                if (w_sel[i]) begin
                    n_rank[i] = '0;
                    if (r_count[i] != {COUNT_BITS{1'b1}}) begin
                        n_count[i] = r_count[i] + COUNT_BITS'(1);
                    end
                end else if (r_valid[i] && (r_rank[i] < w_sel_rank)) begin
                    n_rank[i] = r_rank[i] + RW'(1);
                end
            end
            if (do_insert) begin
                if (w_free_idx == RW'(i)) begin
                    n_valid[i] = 1'b1;
                    n_count[i] = COUNT_BITS'(1);
                    n_rank[i]  = '0;
                end else if (r_valid[i]) begin
                    n_rank[i] = r_rank[i] + RW'(1);
                end
            end
            if (do_drop) begin
                if (w_sel[i]) begin
                    n_valid[i] = 1'b0;
                end else if (r_valid[i] && (r_rank[i] > w_sel_rank)) begin
                    n_rank[i] = r_rank[i] - RW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_adv) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_count[i] <= n_count[i];
                r_rank[i]  <= n_rank[i];
                if (n_write_key && (w_free_idx == RW'(i))) begin
                    r_key[i] <= w_key;
                end
            end
        end
    end

endmodule
